### design/kbrb_pkg.sv
// ----------------------------------------------------------------------------
// kbrb_pkg
// Shared types, constants and slot arithmetic for the keyboard ring buffer.
// ----------------------------------------------------------------------------
package kbrb_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int START_W    = 4;
    localparam int END_W      = 5;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = 16;

    typedef enum logic [0:0] {
        REG_START = 1'b0,
        REG_END   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_ADD_OK  = 3'd0,
        ST_FULL    = 3'd1,
        ST_REMOVED = 3'd2,
        ST_PEEKED  = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_AL_ONLY = 3'd5,
        ST_NONE    = 3'd6
    } t_status;

    typedef enum logic [0:0] {
        REQ_ADD     = 1'b0,
        REQ_SERVICE = 1'b1
    } t_req;

    localparam logic [7:0] FN_READ      = 8'h00;
    localparam logic [7:0] FN_PEEK      = 8'h01;
    localparam logic [7:0] FN_SHIFTS    = 8'h02;
    localparam logic [7:0] FN_AL_ZERO   = 8'h09;
    localparam logic [7:0] FN_EXT_READ  = 8'h10;
    localparam logic [7:0] FN_EXT_PEEK  = 8'h11;

    typedef enum logic [0:0] {
        S_IDLE  = 1'b0,
        S_FETCH = 1'b1
    } t_state;

    typedef struct packed {
        logic [START_W-1:0] start_slot;
        logic [END_W-1:0]   end_slot;
    } t_cfg;

    function automatic logic [START_W-1:0] f_advance(
        input logic [START_W-1:0] slot,
        input t_cfg               cfg
    );
        logic [END_W-1:0] end_eff;
        logic [END_W-1:0] next;
        end_eff = (cfg.end_slot > END_W'(SLOT_COUNT)) ? END_W'(SLOT_COUNT) : cfg.end_slot;
        next    = {1'b0, slot} + END_W'(1);
        if (next >= end_eff) begin
            return cfg.start_slot;
        end
        return next[START_W-1:0];
    endfunction

endpackage

### design/bios_keyboard_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// bios_keyboard_ring_buffer_unit
// Keyboard ring buffer with a BIOS-style keyboard service request port.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  in      | i_in_valid / o_in_stall   | req_type, function_code, key, shifts
//  out     | o_out_valid / i_out_stall | status, reg_al, reg_ah, zero_flag
//  cfg     | psel/penable/pwrite/pready| start slot (0x0), end slot (0x4)
//
//  adds and non-key requests are answered straight from idle; removes and peeks that find a key
//  pass through the fetch state, for the registered read port of the key store
//  synchronous reset clears pointers and control and sets the config to slots 0 to 16; the store is not cleared
//  the input stalls while a key read is in flight or a result waits under stall
// ----------------------------------------------------------------------------
module bios_keyboard_ring_buffer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_function_code,
    input  logic [7:0]                   i_key_ascii,
    input  logic [7:0]                   i_key_scan,
    input  logic [7:0]                   i_shift_flags,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_reg_al,
    output logic [7:0]                   o_reg_ah,
    output logic                         o_zero_flag,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbrb_pkg::ADDR_W-1:0]  paddr,
    input  logic [kbrb_pkg::DATA_W-1:0]  pwdata,
    output logic [kbrb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int SW = kbrb_pkg::START_W;

    kbrb_pkg::t_cfg   w_cfg;
    kbrb_pkg::t_state r_state;
    kbrb_pkg::t_state n_state;

    logic [kbrb_pkg::ENTRY_W-1:0] r_mem [kbrb_pkg::SLOT_COUNT];
    logic [kbrb_pkg::ENTRY_W-1:0] r_rd_data;

    logic [SW-1:0] r_rd_slot;
    logic [SW-1:0] n_rd_slot;
    logic [SW-1:0] r_wr_slot;
    logic [SW-1:0] n_wr_slot;
    logic          r_peek;
    logic          n_peek;

    logic          r_out_valid;
    logic          n_out_valid;
    logic [2:0]    r_out_status;
    logic [2:0]    n_out_status;
    logic [7:0]    r_out_al;
    logic [7:0]    n_out_al;
    logic [7:0]    r_out_ah;
    logic [7:0]    n_out_ah;
    logic          r_out_zf;
    logic          n_out_zf;

    logic          w_accept;
    logic          w_out_take;
    logic          w_load;
    logic          w_mem_wr;
    logic          w_mem_rd;
    logic          w_is_key_fn;
    logic          w_is_peek;
    logic          w_full;
    logic          w_empty;
    logic [SW-1:0] w_wr_next;
    logic [SW-1:0] w_rd_next;

    kbrb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != kbrb_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_wr_next   = kbrb_pkg::f_advance(r_wr_slot, w_cfg);
    assign w_rd_next   = kbrb_pkg::f_advance(r_rd_slot, w_cfg);
    assign w_full      = (w_wr_next == r_rd_slot);
    assign w_empty     = (r_rd_slot == r_wr_slot);
    assign w_is_key_fn = i_function_code inside {kbrb_pkg::FN_READ, kbrb_pkg::FN_EXT_READ,
                                                 kbrb_pkg::FN_PEEK, kbrb_pkg::FN_EXT_PEEK};
    assign w_is_peek   = i_function_code inside {kbrb_pkg::FN_PEEK, kbrb_pkg::FN_EXT_PEEK};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kbrb_pkg::S_IDLE: begin
                if (w_accept && i_req_type == kbrb_pkg::REQ_SERVICE && w_is_key_fn && !w_empty) begin
                    n_state = kbrb_pkg::S_FETCH;
                end
            end
            kbrb_pkg::S_FETCH: n_state = kbrb_pkg::S_IDLE;
            default:           n_state = kbrb_pkg::S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_rd_slot    = r_rd_slot;
        n_wr_slot    = r_wr_slot;
        n_peek       = r_peek;
        n_out_status = r_out_status;
        n_out_al     = r_out_al;
        n_out_ah     = r_out_ah;
        n_out_zf     = r_out_zf;
        w_load       = 1'b0;
        w_mem_wr     = 1'b0;
        w_mem_rd     = 1'b0;
        case (r_state)
            kbrb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_al = 8'h00;
                    n_out_ah = 8'h00;
                    n_out_zf = 1'b0;
                    if (i_req_type == kbrb_pkg::REQ_ADD) begin
                        w_load = 1'b1;
                        if (w_full) begin
                            n_out_status = kbrb_pkg::ST_FULL;
                        end else begin
                            w_mem_wr     = 1'b1;
                            n_wr_slot    = w_wr_next;
                            n_out_status = kbrb_pkg::ST_ADD_OK;
                        end
                    end else if (w_is_key_fn) begin
                        if (w_empty) begin
                            w_load       = 1'b1;
                            n_out_status = kbrb_pkg::ST_EMPTY;
                            n_out_zf     = w_is_peek;
                        end else begin
                            w_mem_rd = 1'b1;
                            n_peek   = w_is_peek;
                            if (!w_is_peek) begin
                                n_rd_slot = w_rd_next;
                            end
                        end
                    end else if (i_function_code == kbrb_pkg::FN_SHIFTS) begin
                        w_load       = 1'b1;
                        n_out_status = kbrb_pkg::ST_AL_ONLY;
                        n_out_al     = i_shift_flags;
                    end else if (i_function_code == kbrb_pkg::FN_AL_ZERO) begin
                        w_load       = 1'b1;
                        n_out_status = kbrb_pkg::ST_AL_ONLY;
                    end else begin
                        w_load       = 1'b1;
                        n_out_status = kbrb_pkg::ST_NONE;
                    end
                end
            end
            kbrb_pkg::S_FETCH: begin
                w_load       = 1'b1;
                n_out_status = r_peek ? kbrb_pkg::ST_PEEKED : kbrb_pkg::ST_REMOVED;
                n_out_al     = r_rd_data[7:0];
                n_out_ah     = r_rd_data[15:8];
                n_out_zf     = 1'b0;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
        n_out_valid = w_load || (r_out_valid && !w_out_take);
    end

    // key store, scan byte high and ascii byte low
    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem[r_wr_slot[kbrb_pkg::SLOT_W-1:0]] <= {i_key_scan, i_key_ascii};
        end
        if (w_mem_rd) begin
            r_rd_data <= r_mem[r_rd_slot[kbrb_pkg::SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kbrb_pkg::S_IDLE;
            r_rd_slot   <= '0;
            r_wr_slot   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_slot   <= n_rd_slot;
            r_wr_slot   <= n_wr_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_peek       <= n_peek;
        r_out_status <= n_out_status;
        r_out_al     <= n_out_al;
        r_out_ah     <= n_out_ah;
        r_out_zf     <= n_out_zf;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_reg_al    = r_out_al;
    assign o_reg_ah    = r_out_ah;
    assign o_zero_flag = r_out_zf;

    a_fetch_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbrb_pkg::S_FETCH) |-> !r_out_valid)
        else $error("result register busy during key fetch");

    a_fetch_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbrb_pkg::S_FETCH) |=> (r_out_valid && r_state == kbrb_pkg::S_IDLE))
        else $error("key fetch did not produce a result");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_valid || r_state == kbrb_pkg::S_FETCH))
        else $error("accepted request produced nothing");

    a_zf_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zf) |-> (r_out_status == kbrb_pkg::ST_EMPTY))
        else $error("zero flag set outside an empty peek");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_wr |-> (w_wr_next != r_rd_slot))
        else $error("key written into a full buffer");

endmodule

### design/kbrb_cfg_regs.sv
// ----------------------------------------------------------------------------
// kbrb_cfg_regs
// APB register file holding the ring region start and end slots.
// ----------------------------------------------------------------------------
module kbrb_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbrb_pkg::ADDR_W-1:0]  paddr,
    input  logic [kbrb_pkg::DATA_W-1:0]  pwdata,
    output logic [kbrb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output kbrb_pkg::t_cfg               o_cfg
);

    kbrb_pkg::t_cfg   r_cfg;
    kbrb_pkg::t_cfg   n_cfg;
    kbrb_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = kbrb_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                kbrb_pkg::REG_START: n_cfg.start_slot = pwdata[kbrb_pkg::START_W-1:0];
                kbrb_pkg::REG_END:   n_cfg.end_slot   = pwdata[kbrb_pkg::END_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_slot <= '0;
            r_cfg.end_slot   <= kbrb_pkg::END_W'(kbrb_pkg::SLOT_COUNT);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            kbrb_pkg::REG_START:
                prdata = {{(kbrb_pkg::DATA_W-kbrb_pkg::START_W){1'b0}}, r_cfg.start_slot};
            kbrb_pkg::REG_END:
                prdata = {{(kbrb_pkg::DATA_W-kbrb_pkg::END_W){1'b0}}, r_cfg.end_slot};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### tb/bios_keyboard_ring_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bios_keyboard_ring_buffer_unit_tb
// Self-checking bench for the keyboard ring buffer and its INT 16h service.
// A scoreboard keeps its own copy of the ring pointers, the key store and the
// region registers, predicts one reply per accepted request and compares each
// reply field by field. Directed requests cover empty, full, every service
// function and byte extremes; random phases follow under several region
// settings, with bursty requests, random output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module bios_keyboard_ring_buffer_unit_tb;

    typedef struct {
        kbrb_pkg::t_req req;
        logic [7:0]     func;
        logic [7:0]     ascii;
        logic [7:0]     scan;
        logic [7:0]     shifts;
    } t_key_request;

    typedef struct {
        kbrb_pkg::t_status status;
        logic [7:0]        al;
        logic [7:0]        ah;
        logic              zf;
    } t_key_reply;

    class int16h_scoreboard;
        logic [15:0] key_store [kbrb_pkg::SLOT_COUNT];
        logic [3:0]  rd_slot;
        logic [3:0]  wr_slot;
        logic [3:0]  start_slot;
        logic [4:0]  end_slot;
        t_key_reply  replies_due [$];
        int          errors;

        function void reset_state();
            rd_slot    = '0;
            wr_slot    = '0;
            start_slot = 4'd0;
            end_slot   = 5'd16;
            errors     = 0;
            replies_due.delete();
        endfunction

        function void set_reg(kbrb_pkg::t_reg_idx idx, logic [31:0] value);
            if (idx == kbrb_pkg::REG_START) begin
                start_slot = value[3:0];
            end else begin
                end_slot = value[4:0];
            end
        endfunction

        function logic [31:0] reg_value(kbrb_pkg::t_reg_idx idx);
            return (idx == kbrb_pkg::REG_START) ? {28'd0, start_slot} : {27'd0, end_slot};
        endfunction

        function bit ring_empty();
            return rd_slot == wr_slot;
        endfunction

        function logic [3:0] next_slot(logic [3:0] slot);
            int lim;
            int nxt;
            lim = (end_slot > kbrb_pkg::SLOT_COUNT) ? kbrb_pkg::SLOT_COUNT : end_slot;
            nxt = slot + 1;
            if (nxt >= lim) return start_slot;
            return nxt[3:0];
        endfunction

        function void note_request(t_key_request r);
            t_key_reply e;
            logic [3:0] nxt;
            bit         peek;
            e.status = kbrb_pkg::ST_NONE;
            e.al     = 8'h00;
            e.ah     = 8'h00;
            e.zf     = 1'b0;
            if (r.req == kbrb_pkg::REQ_ADD) begin
                nxt = next_slot(wr_slot);
                if (nxt == rd_slot) begin
                    e.status = kbrb_pkg::ST_FULL;
                end else begin
                    key_store[wr_slot] = {r.scan, r.ascii};
                    wr_slot = nxt;
                    e.status = kbrb_pkg::ST_ADD_OK;
                end
            end else if (r.func == kbrb_pkg::FN_READ || r.func == kbrb_pkg::FN_EXT_READ ||
                         r.func == kbrb_pkg::FN_PEEK || r.func == kbrb_pkg::FN_EXT_PEEK) begin
                peek = (r.func == kbrb_pkg::FN_PEEK || r.func == kbrb_pkg::FN_EXT_PEEK);
                if (rd_slot == wr_slot) begin
                    e.status = kbrb_pkg::ST_EMPTY;
                    e.zf     = peek;
                end else begin
                    e.al = key_store[rd_slot][7:0];
                    e.ah = key_store[rd_slot][15:8];
                    if (peek) begin
                        e.status = kbrb_pkg::ST_PEEKED;
                    end else begin
                        e.status = kbrb_pkg::ST_REMOVED;
                        rd_slot  = next_slot(rd_slot);
                    end
                end
            end else if (r.func == kbrb_pkg::FN_SHIFTS) begin
                e.status = kbrb_pkg::ST_AL_ONLY;
                e.al     = r.shifts;
            end else if (r.func == kbrb_pkg::FN_AL_ZERO) begin
                e.status = kbrb_pkg::ST_AL_ONLY;
            end
            replies_due.push_back(e);
        endfunction

        function void check_reply(t_key_reply got);
            t_key_reply e;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%t: reply with none due, status %0d al %02h ah %02h zf %0b",
                         $time, got.status, got.al, got.ah, got.zf);
                return;
            end
            e = replies_due.pop_front();
            if (got.status != e.status) begin
                errors++;
                $display("%t: status expected %0d actual %0d", $time, e.status, got.status);
            end
            if (got.al != e.al) begin
                errors++;
                $display("%t: reg_al expected %02h actual %02h", $time, e.al, got.al);
            end
            if (got.ah != e.ah) begin
                errors++;
                $display("%t: reg_ah expected %02h actual %02h", $time, e.ah, got.ah);
            end
            if (got.zf != e.zf) begin
                errors++;
                $display("%t: zero_flag expected %0b actual %0b", $time, e.zf, got.zf);
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_req_type;
    logic [7:0]                  i_function_code;
    logic [7:0]                  i_key_ascii;
    logic [7:0]                  i_key_scan;
    logic [7:0]                  i_shift_flags;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [2:0]                  o_status;
    logic [7:0]                  o_reg_al;
    logic [7:0]                  o_reg_ah;
    logic                        o_zero_flag;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [kbrb_pkg::ADDR_W-1:0] paddr;
    logic [kbrb_pkg::DATA_W-1:0] pwdata;
    logic [kbrb_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    int16h_scoreboard ring;
    int               hold_off_req;
    int               hold_off_done;

    int phase_start [10] = '{0, 0, 15, 3, 0, 10, 7, 12, 0, 0};
    int phase_end   [10] = '{16, 31, 16, 9, 1, 0, 7, 5, 0, 0};

    bios_keyboard_ring_buffer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_function_code (i_function_code),
        .i_key_ascii     (i_key_ascii),
        .i_key_scan      (i_key_scan),
        .i_shift_flags   (i_shift_flags),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_reg_al        (o_reg_al),
        .o_reg_ah        (o_reg_ah),
        .o_zero_flag     (o_zero_flag),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_key_request make_request(kbrb_pkg::t_req req, logic [7:0] fn,
                                                  logic [7:0] a, logic [7:0] s,
                                                  logic [7:0] sh);
        t_key_request r;
        r.req    = req;
        r.func   = fn;
        r.ascii  = a;
        r.scan   = s;
        r.shifts = sh;
        return r;
    endfunction

    function automatic t_key_request random_request(int add_pct);
        t_key_request r;
        int           sel;
        r = make_request(kbrb_pkg::REQ_ADD, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        if ($urandom_range(0, 99) >= add_pct) begin
            r.req = kbrb_pkg::REQ_SERVICE;
            sel   = $urandom_range(0, 9);
            case (sel)
                0, 1:    r.func = kbrb_pkg::FN_READ;
                2:       r.func = kbrb_pkg::FN_EXT_READ;
                3, 4:    r.func = kbrb_pkg::FN_PEEK;
                5:       r.func = kbrb_pkg::FN_EXT_PEEK;
                6:       r.func = kbrb_pkg::FN_SHIFTS;
                7:       r.func = kbrb_pkg::FN_AL_ZERO;
                default: r.func = 8'($urandom);
            endcase
        end
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_key_request r);
        i_in_valid      <= 1'b1;
        i_req_type      <= r.req;
        i_function_code <= r.func;
        i_key_ascii     <= r.ascii;
        i_key_scan      <= r.scan;
        i_shift_flags   <= r.shifts;
        do @(posedge i_clk); while (o_in_stall);
        ring.note_request(r);
        @(negedge i_clk);
    endtask

    // empty the ring so the region can move without exposing unwritten slots
    task automatic settle();
        while (!ring.ring_empty()) begin
            send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_READ,
                                      8'($urandom), 8'($urandom), 8'($urandom)));
        end
        i_in_valid <= 1'b0;
        while (ring.replies_due.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input kbrb_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ring.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (rd !== ring.reg_value(idx)) begin
            ring.errors++;
            $display("%t: register %0d readback expected %08h actual %08h",
                     $time, idx, ring.reg_value(idx), rd);
        end
    endtask

    task automatic run_random(input int count);
        int left;
        int burst;
        int gap;
        int add_pct;
        left    = count;
        add_pct = 50;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 2) == 0) add_pct = 20 + 30 * $urandom_range(0, 2);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_request(random_request(add_pct));
                left--;
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // result side
    initial begin
        t_key_reply got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.status = kbrb_pkg::t_status'(o_status);
                got.al     = o_reg_al;
                got.ah     = o_reg_ah;
                got.zf     = o_zero_flag;
                ring.check_reply(got);
            end
        end
    end

    // output stall pattern, with a long hold-off on request
    initial begin
        int mode;
        int span;
        int pct;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req > hold_off_done) begin
                hold_off_done++;
                repeat (300) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
                pct  = $urandom_range(10, 70);
                repeat (span) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 99) < pct);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    initial begin
        int s;
        int e;
        ring            = new();
        hold_off_req    = 0;
        hold_off_done   = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_req_type      = 1'b0;
        i_function_code = 8'h00;
        i_key_ascii     = 8'h00;
        i_key_scan      = 8'h00;
        i_shift_flags   = 8'h00;
        i_out_stall     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        ring.reset_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // small region of three usable slots for the directed part
        cfg_write(kbrb_pkg::REG_START, 32'd0);
        cfg_write(kbrb_pkg::REG_END, 32'd4);

        // empty ring
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_PEEK,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_EXT_PEEK,
                                  8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_EXT_READ,
                                  8'hFF, 8'hFF, 8'hFF));
        // non-key functions
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_SHIFTS,
                                  8'h00, 8'h00, 8'hFF));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_SHIFTS,
                                  8'hFF, 8'hFF, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_AL_ZERO,
                                  8'h12, 8'h34, 8'hFF));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, 8'h03, 8'h00, 8'h00, 8'h00));
        // fill to full
        send_request(make_request(kbrb_pkg::REQ_ADD, 8'hFF, 8'hFF, 8'h00, 8'hFF));
        send_request(make_request(kbrb_pkg::REQ_ADD, 8'h00, 8'h00, 8'hFF, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_ADD, 8'h10, 8'hA5, 8'h5A, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_ADD, 8'h00, 8'h3C, 8'hC3, 8'h00));
        // drain with peeks and both read flavors, wrapping at the end slot
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_PEEK,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_EXT_PEEK,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_EXT_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_ADD, 8'h00, 8'h7E, 8'h81, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_EXT_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_READ,
                                  8'h00, 8'h00, 8'h00));
        send_request(make_request(kbrb_pkg::REQ_SERVICE, kbrb_pkg::FN_PEEK,
                                  8'h00, 8'h00, 8'h00));

        for (int p = 0; p < 10; p++) begin
            settle();
            s = (p >= 8) ? $urandom_range(0, 15) : phase_start[p];
            e = (p >= 8) ? $urandom_range(0, 31) : phase_end[p];
            cfg_write(kbrb_pkg::REG_START, ($urandom & 32'hFFFF_FFF0) | 32'(s));
            cfg_write(kbrb_pkg::REG_END, ($urandom & 32'hFFFF_FFE0) | 32'(e));
            if (p == 1) hold_off_req++;
            run_random(120);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (ring.errors == 0 && ring.replies_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
design/kbrb_pkg.sv
design/kbrb_cfg_regs.sv
design/bios_keyboard_ring_buffer_unit.sv
tb/bios_keyboard_ring_buffer_unit_tb.sv
